[sv/mpfe_pkg.sv]
package mpfe_pkg;

	localparam int MAX_ATOMS = 64;
	localparam int IDX_W = 6;
	localparam int CNT_W = 7;

	localparam logic [31:0] LN2_Q32 = 32'd2977044472;
	localparam logic [63:0] ONE_Q32 = 64'h0000_0001_0000_0000;
	localparam logic [63:0] INT64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [3:0] TAYLOR_TERMS = 4'd12;

	localparam logic [2:0] REG_WELL_DEPTH = 3'd0;
	localparam logic [2:0] REG_WIDTH_FACTOR = 3'd1;
	localparam logic [2:0] REG_EQ_DIST = 3'd2;
	localparam logic [2:0] REG_CUTOFF = 3'd3;

	typedef struct packed {
		logic ovf;
		logic signed [47:0] val;
	} fsat_t;

	// 48-bit accumulator plus signed delta, clamped to -2^47 .. 2^47-1
	function automatic fsat_t fsat_add(input logic signed [47:0] acc,
		input logic signed [49:0] dlt);
		logic signed [50:0] s;
		fsat_t r;
		s = {{3{acc[47]}}, acc} + {dlt[49], dlt};
		r.ovf = !((s[50:47] == 4'b0000) || (s[50:47] == 4'b1111));
		if (!r.ovf) begin
			r.val = s[47:0];
		end else if (s[50]) begin
			r.val = {1'b1, 47'd0};
		end else begin
			r.val = {1'b0, {47{1'b1}}};
		end
		return r;
	endfunction

endpackage

[sv/morse_pair_force_energy.sv]
// channel   | dir | tdata (lsb first)                                  | tlast       | tuser
// s_axis    | in  | pos_x[31:0] pos_y[63:32] pos_z[95:64]             | last_atom   | -
// m_axis    | out | atom_index, force_x/y/z, total_energy, pad       | last_result | overflow_flag
// cfg       | in  | cfg_we, cfg_index, cfg_data (32-bit registers)     | -           | -
//
// Loading accepts one atom per cycle. The last atom starts a run: a clear sweep over the
// force memories, then each pair inside the cutoff runs on the shared 32x32 multiplier,
// used as a 4-pass 64x64 unit, and the bit-serial divider: 15 divides, 19 multiply calls,
// 32 root steps, 7 ln2 steps, with the Taylor series skipped when exp overflows. Far pairs
// stop after the root. Each result is read in S_ORD and then held until m_axis_tready.
// s_axis_tready is high only while idle. Reset clears counts and flags and sets config defaults.
module morse_pair_force_energy (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [95:0]  s_axis_tdata,   // pos_x, pos_y, pos_z
	input  logic         s_axis_tlast,   // last_atom
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [215:0] m_axis_tdata,   // atom_index, force_x, force_y, force_z, total_energy
	output logic         m_axis_tlast,   // last_result
	output logic         m_axis_tuser    // overflow_flag
);

	localparam logic [5:0] S_IDLE = 6'd0, S_CLR = 6'd1, S_CHK = 6'd2, S_RDI = 6'd3,
		S_RDJ = 6'd4, S_DIFF = 6'd5, S_SQ0 = 6'd6, S_SQ1 = 6'd7, S_SQ2 = 6'd8,
		S_SQRT = 6'd9, S_RCHK = 6'd10, S_P = 6'd11, S_EXP0 = 6'd12, S_TAY = 6'd13,
		S_TAYD = 6'd14, S_TAYA = 6'd15, S_EXPF = 6'd16, S_MO = 6'd17, S_EN1 = 6'd18,
		S_EN2 = 6'd19, S_T1 = 6'd20, S_T2 = 6'd21, S_U = 6'd22, S_FM = 6'd23,
		S_FA = 6'd24, S_FI = 6'd25, S_FJ = 6'd26, S_NEXTJ = 6'd27, S_ORD = 6'd28,
		S_OWAIT = 6'd29, S_MUL = 6'd30, S_MULF = 6'd31, S_DIV = 6'd32, S_LN2 = 6'd33;

	logic [5:0] state_q, ret_q;
	logic [31:0] wd_q, wf_q, re_q, cut_q;

	logic [31:0] pos_x_mem [mpfe_pkg::MAX_ATOMS];
	logic [31:0] pos_y_mem [mpfe_pkg::MAX_ATOMS];
	logic [31:0] pos_z_mem [mpfe_pkg::MAX_ATOMS];
	logic signed [47:0] fx_mem [mpfe_pkg::MAX_ATOMS];
	logic signed [47:0] fy_mem [mpfe_pkg::MAX_ATOMS];
	logic signed [47:0] fz_mem [mpfe_pkg::MAX_ATOMS];

	logic [31:0] px_rd_q, py_rd_q, pz_rd_q;
	logic signed [47:0] fx_rd_q, fy_rd_q, fz_rd_q;

	logic [mpfe_pkg::CNT_W-1:0] cnt_q, j_q;
	logic [mpfe_pkg::IDX_W-1:0] ccnt_q, i_q, oi_q;
	logic [1:0] k_q, mcnt_q;
	logic [31:0] xi_q, yi_q, zi_q;
	logic [2:0][31:0] ax_q;
	logic [2:0] dneg_q;
	logic [63:0] s_q, rs_q, bit_q, srem_q;
	logic [31:0] r_q, ad_q, f_q;
	logic pos_q;
	logic [63:0] dv_q;
	logic [31:0] ds_q, rm_q;
	logic [5:0] dcnt_q;
	logic [63:0] ma_q, mb_q, mr_q;
	logic sh16_q;
	logic [127:0] prod_q;
	logic [5:0] sh_q;
	logic shbig_q;
	logic [63:0] term_q, tsum_q, e_q, mo_q, t4_q, en_q;
	logic [3:0] tn_q;
	logic om_neg_q;
	logic signed [49:0] dl_q;
	logic ovf_q;

	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;
	logic [127:0] prod_add;
	logic [5:0] prd_addr, frd_addr;
	logic signed [32:0] dx, dy, dz, dr;
	logic [31:0] ax, ay, az, ad;
	logic [64:0] sq_sum, en_sum;
	logic [63:0] sqrt_try;
	logic [32:0] rem_n;
	logic [33:0] dsub;
	logic [63:0] e_shl, e_shr, mo;
	logic [55:0] fm_raw;
	logic [48:0] fm;
	logic dneg_k;
	logic signed [49:0] di;
	logic signed [47:0] frd;
	mpfe_pkg::fsat_t fs_i, fs_j;
	logic [2:0] fwe;
	logic [5:0] fwaddr;
	logic signed [47:0] fwdata;
	logic in_acc, last_out;

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = (state_q == S_OWAIT);
	assign last_out = ({1'b0, oi_q} + 7'd1) == cnt_q;
	assign m_axis_tdata = {2'b00, en_q, fz_rd_q, fy_rd_q, fx_rd_q, oi_q};
	assign m_axis_tlast = last_out;
	assign m_axis_tuser = ovf_q;

	always_comb begin
		mul_a = 32'd0;
		mul_b = 32'd0;
		case (state_q)
			S_SQ0: begin mul_a = ax_q[0]; mul_b = ax_q[0]; end
			S_SQ1: begin mul_a = ax_q[1]; mul_b = ax_q[1]; end
			S_SQ2: begin mul_a = ax_q[2]; mul_b = ax_q[2]; end
			S_P: begin mul_a = wf_q; mul_b = ad_q; end
			S_EN2: begin mul_a = wd_q; mul_b = wf_q; end
			S_MUL: begin
				mul_a = mcnt_q[1] ? ma_q[63:32] : ma_q[31:0];
				mul_b = (mcnt_q == 2'd1 || mcnt_q == 2'd3) ? mb_q[63:32] : mb_q[31:0];
			end
			default: ;
		endcase
	end
	assign mul_p = mul_a * mul_b;

	always_comb begin
		case (mcnt_q)
			2'd0: prod_add = prod_q + {64'd0, mul_p};
			2'd3: prod_add = prod_q + {mul_p, 64'd0};
			default: prod_add = prod_q + {32'd0, mul_p, 32'd0};
		endcase
	end

	assign prd_addr = (state_q == S_RDI) ? i_q : j_q[5:0];
	always_comb begin
		case (state_q)
			S_FA: frd_addr = i_q;
			S_FI: frd_addr = j_q[5:0];
			default: frd_addr = oi_q;
		endcase
	end

	assign dx = {xi_q[31], xi_q} - {px_rd_q[31], px_rd_q};
	assign dy = {yi_q[31], yi_q} - {py_rd_q[31], py_rd_q};
	assign dz = {zi_q[31], zi_q} - {pz_rd_q[31], pz_rd_q};
	assign ax = dx[32] ? 32'(-dx) : dx[31:0];
	assign ay = dy[32] ? 32'(-dy) : dy[31:0];
	assign az = dz[32] ? 32'(-dz) : dz[31:0];

	assign sq_sum = {1'b0, s_q} + {1'b0, mul_p};
	assign sqrt_try = rs_q + bit_q;
	assign dr = {1'b0, rs_q[31:0]} - {1'b0, re_q};
	assign ad = dr[32] ? 32'(-dr) : dr[31:0];

	// restoring divider, one quotient bit per cycle
	assign rem_n = {rm_q, dv_q[63]};
	assign dsub = {1'b0, rem_n} - {2'b00, ds_q};

	assign e_shl = tsum_q << sh_q[4:0];
	assign e_shr = tsum_q >> sh_q;
	assign mo = (e_q > mpfe_pkg::ONE_Q32) ? e_q - mpfe_pkg::ONE_Q32 : mpfe_pkg::ONE_Q32 - e_q;
	assign en_sum = {1'b0, en_q} + {1'b0, mr_q};

	assign fm_raw = mr_q[63:8];
	assign fm = (fm_raw > 56'h1_0000_0000_0000) ? 49'h1_0000_0000_0000 : fm_raw[48:0];
	assign dneg_k = dneg_q[k_q];
	// delta on atom i; atom j gets the opposite
	assign di = (om_neg_q ^ dneg_k) ? {1'b0, fm} : -{1'b0, fm};

	always_comb begin
		case (k_q)
			2'd0: frd = fx_rd_q;
			2'd1: frd = fy_rd_q;
			default: frd = fz_rd_q;
		endcase
	end
	assign fs_i = mpfe_pkg::fsat_add(frd, dl_q);
	assign fs_j = mpfe_pkg::fsat_add(frd, -dl_q);

	always_comb begin
		fwe = 3'b000;
		fwaddr = ccnt_q;
		fwdata = '0;
		case (state_q)
			S_CLR: fwe = 3'b111;
			S_FI: begin
				fwe = 3'b001 << k_q;
				fwaddr = i_q;
				fwdata = fs_i.val;
			end
			S_FJ: begin
				fwe = 3'b001 << k_q;
				fwaddr = j_q[5:0];
				fwdata = fs_j.val;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_acc && cnt_q < mpfe_pkg::CNT_W'(mpfe_pkg::MAX_ATOMS)) begin
			pos_x_mem[cnt_q[5:0]] <= s_axis_tdata[31:0];
			pos_y_mem[cnt_q[5:0]] <= s_axis_tdata[63:32];
			pos_z_mem[cnt_q[5:0]] <= s_axis_tdata[95:64];
		end
		px_rd_q <= pos_x_mem[prd_addr];
		py_rd_q <= pos_y_mem[prd_addr];
		pz_rd_q <= pos_z_mem[prd_addr];
	end

	always_ff @(posedge clk) begin
		if (fwe[0]) fx_mem[fwaddr] <= fwdata;
		if (fwe[1]) fy_mem[fwaddr] <= fwdata;
		if (fwe[2]) fz_mem[fwaddr] <= fwdata;
		fx_rd_q <= fx_mem[frd_addr];
		fy_rd_q <= fy_mem[frd_addr];
		fz_rd_q <= fz_mem[frd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wd_q <= 32'd65536;
			wf_q <= 32'd65536;
			re_q <= 32'd65536;
			cut_q <= 32'd655360;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mpfe_pkg::REG_WELL_DEPTH: wd_q <= cfg_data;
				mpfe_pkg::REG_WIDTH_FACTOR: wf_q <= cfg_data;
				mpfe_pkg::REG_EQ_DIST: re_q <= cfg_data;
				mpfe_pkg::REG_CUTOFF: cut_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q <= S_IDLE;
			cnt_q <= '0;
			ccnt_q <= '0;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			oi_q <= '0;
			mcnt_q <= '0;
			dcnt_q <= '0;
			tn_q <= '0;
			en_q <= '0;
			ovf_q <= 1'b0;
			xi_q <= '0; yi_q <= '0; zi_q <= '0;
			ax_q <= '0; dneg_q <= '0;
			s_q <= '0; rs_q <= '0; bit_q <= '0; srem_q <= '0;
			r_q <= '0; ad_q <= '0; f_q <= '0; pos_q <= 1'b0;
			dv_q <= '0; ds_q <= '0; rm_q <= '0;
			ma_q <= '0; mb_q <= '0; mr_q <= '0; sh16_q <= 1'b0; prod_q <= '0;
			sh_q <= '0; shbig_q <= 1'b0;
			term_q <= '0; tsum_q <= '0; e_q <= '0; mo_q <= '0; t4_q <= '0;
			om_neg_q <= 1'b0;
			dl_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (cnt_q < mpfe_pkg::CNT_W'(mpfe_pkg::MAX_ATOMS)) begin
							cnt_q <= cnt_q + 7'd1;
						end else begin
							ovf_q <= 1'b1;
						end
						if (s_axis_tlast) begin
							ccnt_q <= '0;
							en_q <= '0;
							state_q <= S_CLR;
						end
					end
				end
				S_CLR: begin
					ccnt_q <= ccnt_q + 6'd1;
					if (({1'b0, ccnt_q} + 7'd1) >= cnt_q) begin
						i_q <= '0;
						j_q <= 7'd1;
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (j_q < cnt_q) begin
						state_q <= S_RDI;
					end else if (({2'b00, i_q} + 8'd2) >= {1'b0, cnt_q}) begin
						oi_q <= '0;
						state_q <= S_ORD;
					end else begin
						i_q <= i_q + 6'd1;
						j_q <= {1'b0, i_q} + 7'd2;
					end
				end
				S_RDI: state_q <= S_RDJ;
				S_RDJ: begin
					xi_q <= px_rd_q;
					yi_q <= py_rd_q;
					zi_q <= pz_rd_q;
					state_q <= S_DIFF;
				end
				S_DIFF: begin
					ax_q <= {az, ay, ax};
					dneg_q <= {dz[32], dy[32], dx[32]};
					state_q <= S_SQ0;
				end
				S_SQ0: begin
					s_q <= mul_p;
					state_q <= S_SQ1;
				end
				S_SQ1: begin
					s_q <= sq_sum[63:0];
					state_q <= sq_sum[64] ? S_NEXTJ : S_SQ2;
				end
				S_SQ2: begin
					srem_q <= sq_sum[63:0];
					rs_q <= '0;
					bit_q <= 64'h4000_0000_0000_0000;
					state_q <= sq_sum[64] ? S_NEXTJ : S_SQRT;
				end
				S_SQRT: begin
					if (srem_q >= sqrt_try) begin
						srem_q <= srem_q - sqrt_try;
						rs_q <= (rs_q >> 1) + bit_q;
					end else begin
						rs_q <= rs_q >> 1;
					end
					bit_q <= bit_q >> 2;
					if (bit_q[0]) state_q <= S_RCHK;
				end
				S_RCHK: begin
					if (rs_q[31:0] == 32'd0 || rs_q[31:0] > cut_q) begin
						state_q <= S_NEXTJ;
					end else begin
						r_q <= rs_q[31:0];
						ad_q <= ad;
						pos_q <= dr[32];
						state_q <= S_P;
					end
				end
				S_P: begin
					// divide by ln2 with compare and subtract from 64*ln2 down
					srem_q <= mul_p;
					bit_q <= {26'd0, mpfe_pkg::LN2_Q32, 6'd0};
					dv_q <= '0;
					dcnt_q <= '0;
					state_q <= S_LN2;
				end
				S_LN2: begin
					// quotient bit 6 set means 64 or more: exp saturates either way
					if (srem_q >= bit_q) begin
						srem_q <= srem_q - bit_q;
						dv_q <= {dv_q[62:0], 1'b1};
					end else begin
						dv_q <= {dv_q[62:0], 1'b0};
					end
					bit_q <= bit_q >> 1;
					dcnt_q <= dcnt_q + 6'd1;
					if (dcnt_q == 6'd6) state_q <= S_EXP0;
				end
				S_EXP0: begin
					// dv_q = quotient by ln2, srem_q = remainder
					term_q <= mpfe_pkg::ONE_Q32;
					tsum_q <= mpfe_pkg::ONE_Q32;
					tn_q <= 4'd1;
					state_q <= S_TAY;
					if (pos_q) begin
						f_q <= srem_q[31:0];
						sh_q <= {1'b0, dv_q[4:0]};
						shbig_q <= 1'b0;
						if (|dv_q[63:5]) begin
							e_q <= '1;
							ovf_q <= 1'b1;
							state_q <= S_MO;
						end
					end else if (srem_q[31:0] == 32'd0) begin
						f_q <= '0;
						sh_q <= dv_q[5:0];
						shbig_q <= |dv_q[63:6];
					end else begin
						f_q <= mpfe_pkg::LN2_Q32 - srem_q[31:0];
						sh_q <= dv_q[5:0] + 6'd1;
						shbig_q <= (|dv_q[63:6]) || (dv_q[5:0] == 6'd63);
					end
				end
				S_TAY: begin
					ma_q <= term_q;
					mb_q <= {32'd0, f_q};
					sh16_q <= 1'b0;
					prod_q <= '0;
					mcnt_q <= '0;
					ret_q <= S_TAYD;
					state_q <= S_MUL;
				end
				S_TAYD: begin
					dv_q <= mr_q;
					ds_q <= {28'd0, tn_q};
					rm_q <= '0;
					dcnt_q <= '0;
					ret_q <= S_TAYA;
					state_q <= S_DIV;
				end
				S_TAYA: begin
					term_q <= dv_q;
					tsum_q <= tsum_q + dv_q;
					if (tn_q == mpfe_pkg::TAYLOR_TERMS) begin
						state_q <= S_EXPF;
					end else begin
						tn_q <= tn_q + 4'd1;
						state_q <= S_TAY;
					end
				end
				S_EXPF: begin
					if (pos_q) e_q <= e_shl;
					else e_q <= shbig_q ? 64'd0 : e_shr;
					state_q <= S_MO;
				end
				S_MO: begin
					om_neg_q <= e_q > mpfe_pkg::ONE_Q32;
					mo_q <= mo;
					ma_q <= {32'd0, wd_q};
					mb_q <= mo;
					sh16_q <= 1'b1;
					prod_q <= '0;
					mcnt_q <= '0;
					ret_q <= S_EN1;
					state_q <= S_MUL;
				end
				S_EN1: begin
					ma_q <= mr_q;
					mb_q <= mo_q;
					sh16_q <= 1'b0;
					prod_q <= '0;
					mcnt_q <= '0;
					ret_q <= S_EN2;
					state_q <= S_MUL;
				end
				S_EN2: begin
					if (en_sum[64] || en_sum[63]) begin
						en_q <= mpfe_pkg::INT64_MAX;
						ovf_q <= 1'b1;
					end else begin
						en_q <= en_sum[63:0];
					end
					ma_q <= mul_p;
					mb_q <= mo_q;
					sh16_q <= 1'b0;
					prod_q <= '0;
					mcnt_q <= '0;
					ret_q <= S_T1;
					state_q <= S_MUL;
				end
				S_T1: begin
					ma_q <= mr_q;
					mb_q <= e_q;
					prod_q <= '0;
					mcnt_q <= '0;
					ret_q <= S_T2;
					state_q <= S_MUL;
				end
				S_T2: begin
					if (mr_q[63]) begin
						t4_q <= '1;
						ovf_q <= 1'b1;
					end else begin
						t4_q <= {mr_q[62:0], 1'b0};
					end
					k_q <= '0;
					state_q <= S_U;
				end
				S_U: begin
					dv_q <= {ax_q[k_q], 32'd0};
					ds_q <= r_q;
					rm_q <= '0;
					dcnt_q <= '0;
					ret_q <= S_FM;
					state_q <= S_DIV;
				end
				S_FM: begin
					ma_q <= t4_q;
					mb_q <= dv_q;
					sh16_q <= 1'b0;
					prod_q <= '0;
					mcnt_q <= '0;
					ret_q <= S_FA;
					state_q <= S_MUL;
				end
				S_FA: begin
					dl_q <= di;
					state_q <= S_FI;
				end
				S_FI: begin
					if (fs_i.ovf) ovf_q <= 1'b1;
					state_q <= S_FJ;
				end
				S_FJ: begin
					if (fs_j.ovf) ovf_q <= 1'b1;
					if (k_q == 2'd2) begin
						state_q <= S_NEXTJ;
					end else begin
						k_q <= k_q + 2'd1;
						state_q <= S_U;
					end
				end
				S_NEXTJ: begin
					j_q <= j_q + 7'd1;
					state_q <= S_CHK;
				end
				S_ORD: state_q <= S_OWAIT;
				S_OWAIT: begin
					if (m_axis_tready) begin
						if (last_out) begin
							cnt_q <= '0;
							ovf_q <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							oi_q <= oi_q + 6'd1;
							state_q <= S_ORD;
						end
					end
				end
				S_MUL: begin
					prod_q <= prod_add;
					mcnt_q <= mcnt_q + 2'd1;
					if (mcnt_q == 2'd3) state_q <= S_MULF;
				end
				S_MULF: begin
					if (sh16_q) begin
						if (|prod_q[127:80]) begin
							mr_q <= '1;
							ovf_q <= 1'b1;
						end else begin
							mr_q <= prod_q[79:16];
						end
					end else begin
						if (|prod_q[127:96]) begin
							mr_q <= '1;
							ovf_q <= 1'b1;
						end else begin
							mr_q <= prod_q[95:32];
						end
					end
					state_q <= ret_q;
				end
				S_DIV: begin
					if (!dsub[33]) begin
						rm_q <= dsub[31:0];
						dv_q <= {dv_q[62:0], 1'b1};
					end else begin
						rm_q <= rem_n[31:0];
						dv_q <= {dv_q[62:0], 1'b0};
					end
					dcnt_q <= dcnt_q + 6'd1;
					if (dcnt_q == 6'd63) state_q <= ret_q;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[test/tb_top.sv]
module tb_top;

	typedef struct {
		logic [5:0]  atom_index;
		logic [47:0] force_x;
		logic [47:0] force_y;
		logic [47:0] force_z;
		logic [63:0] total_energy;
		logic        last_result;
		logic        overflow_flag;
	} atom_result_t;

	localparam longint FORCE_MAX = (64'sd1 <<< 47) - 1;
	localparam longint FORCE_MIN = -(64'sd1 <<< 47);
	localparam int STALL_LIMIT = 300000;

	class morse_scoreboard;
		logic [31:0]  well_depth = 32'd65536;
		logic [31:0]  width_factor = 32'd65536;
		logic [31:0]  eq_dist = 32'd65536;
		logic [31:0]  cutoff = 32'd655360;
		longint       pos_x[mpfe_pkg::MAX_ATOMS];
		longint       pos_y[mpfe_pkg::MAX_ATOMS];
		longint       pos_z[mpfe_pkg::MAX_ATOMS];
		longint       force_acc[3*mpfe_pkg::MAX_ATOMS];
		longint       energy_acc;
		int           loaded;
		bit           sat_seen;
		atom_result_t expected_results[$];
		int           errors;

		function void set_reg(logic [2:0] idx, logic [31:0] val);
			case (idx)
				mpfe_pkg::REG_WELL_DEPTH: well_depth = val;
				mpfe_pkg::REG_WIDTH_FACTOR: width_factor = val;
				mpfe_pkg::REG_EQ_DIST: eq_dist = val;
				mpfe_pkg::REG_CUTOFF: cutoff = val;
				default: ;
			endcase
		endfunction

		// full product, shifted, clamped to 64 bits
		function logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, int s);
			logic [127:0] p;
			p = {64'd0, a} * {64'd0, b};
			if ((p >> (64 + s)) != 0) begin
				sat_seen = 1;
				return '1;
			end
			return 64'(p >> s);
		endfunction

		function logic [63:0] int_sqrt(logic [63:0] v);
			logic [63:0] res, b;
			res = 0;
			b = 64'd1 << 62;
			for (int it = 0; it < 32; it++) begin
				if (v >= res + b) begin
					v = v - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
			return res;
		endfunction

		function logic [63:0] exp_q(logic [63:0] p, bit positive);
			logic [63:0] ln2, q, rem, f, term, sum, sh;
			ln2 = 64'(mpfe_pkg::LN2_Q32);
			q = p / ln2;
			rem = p % ln2;
			sh = 0;
			if (positive) begin
				if (q >= 32) begin
					sat_seen = 1;
					return '1;
				end
				f = rem;
			end else if (rem == 0) begin
				f = 0;
				sh = q;
			end else begin
				f = ln2 - rem;
				sh = q + 1;
			end
			term = mpfe_pkg::ONE_Q32;
			sum = mpfe_pkg::ONE_Q32;
			for (int n = 1; n <= 12; n++) begin
				term = ((term * f) >> 32) / 64'(n);
				sum = sum + term;
			end
			if (positive)
				return sum << q;
			return (sh >= 64) ? 64'd0 : sum >> sh;
		endfunction

		function void add_force(int idx, longint c);
			longint s;
			s = force_acc[idx] + c;
			if (s > FORCE_MAX) begin
				s = FORCE_MAX;
				sat_seen = 1;
			end
			if (s < FORCE_MIN) begin
				s = FORCE_MIN;
				sat_seen = 1;
			end
			force_acc[idx] = s;
		endfunction

		function void eval_pair(int i, int j);
			longint      d[3];
			logic [63:0] a[3];
			logic [63:0] s, s2, r, ad, e, mo, pe, t, t4, u, fm;
			longint      dr, c;
			bit          om_neg;
			d[0] = pos_x[i] - pos_x[j];
			d[1] = pos_y[i] - pos_y[j];
			d[2] = pos_z[i] - pos_z[j];
			for (int k = 0; k < 3; k++)
				a[k] = (d[k] < 0) ? 64'(-d[k]) : 64'(d[k]);
			s = a[0] * a[0] + a[1] * a[1];
			if (s < a[0] * a[0])
				return;
			s2 = s + a[2] * a[2];
			if (s2 < s)
				return;
			r = int_sqrt(s2);
			if (r == 0 || r > 64'(cutoff))
				return;
			dr = longint'(r) - longint'({32'd0, eq_dist});
			ad = (dr < 0) ? 64'(-dr) : 64'(dr);
			e = exp_q(64'(width_factor) * ad, dr < 0);
			om_neg = e > mpfe_pkg::ONE_Q32;
			mo = om_neg ? e - mpfe_pkg::ONE_Q32 : mpfe_pkg::ONE_Q32 - e;
			pe = mul_shift(mul_shift(64'(well_depth), mo, 16), mo, 32);
			if (pe > 64'(mpfe_pkg::INT64_MAX) - 64'(energy_acc)) begin
				energy_acc = longint'(mpfe_pkg::INT64_MAX);
				sat_seen = 1;
			end else begin
				energy_acc = energy_acc + longint'(pe);
			end
			t = mul_shift(mul_shift(64'(well_depth) * 64'(width_factor), mo, 32), e, 32);
			if (t[63]) begin
				t4 = '1;
				sat_seen = 1;
			end else begin
				t4 = t << 1;
			end
			for (int k = 0; k < 3; k++) begin
				u = (a[k] << 32) / r;
				fm = mul_shift(t4, u, 32) >> 8;
				if (fm > (64'd1 << 48))
					fm = 64'd1 << 48;
				c = longint'(fm);
				if (om_neg != (d[k] < 0))
					c = -c;
				add_force(3 * i + k, -c);
				add_force(3 * j + k, c);
			end
		endfunction

		function void note_atom(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit last);
			atom_result_t res;
			if (loaded < mpfe_pkg::MAX_ATOMS) begin
				pos_x[loaded] = longint'(signed'(x));
				pos_y[loaded] = longint'(signed'(y));
				pos_z[loaded] = longint'(signed'(z));
				loaded++;
			end else begin
				sat_seen = 1;
			end
			if (!last)
				return;
			foreach (force_acc[k])
				force_acc[k] = 0;
			energy_acc = 0;
			for (int i = 0; i < loaded; i++)
				for (int j = i + 1; j < loaded; j++)
					eval_pair(i, j);
			for (int i = 0; i < loaded; i++) begin
				res.atom_index = 6'(i);
				res.force_x = force_acc[3*i][47:0];
				res.force_y = force_acc[3*i+1][47:0];
				res.force_z = force_acc[3*i+2][47:0];
				res.total_energy = energy_acc;
				res.last_result = (i + 1 == loaded);
				res.overflow_flag = sat_seen;
				expected_results.push_back(res);
			end
			loaded = 0;
			sat_seen = 0;
		endfunction

		function void check_result(logic [215:0] data, logic last, logic user);
			atom_result_t x;
			if (expected_results.size() == 0) begin
				$error("unexpected result transaction, atom_index %0d", data[5:0]);
				errors++;
				return;
			end
			x = expected_results.pop_front();
			if (data[5:0] !== x.atom_index) begin
				$error("atom_index exp %0d got %0d", x.atom_index, data[5:0]);
				errors++;
			end
			if (data[53:6] !== x.force_x) begin
				$error("force_x exp %h got %h", x.force_x, data[53:6]);
				errors++;
			end
			if (data[101:54] !== x.force_y) begin
				$error("force_y exp %h got %h", x.force_y, data[101:54]);
				errors++;
			end
			if (data[149:102] !== x.force_z) begin
				$error("force_z exp %h got %h", x.force_z, data[149:102]);
				errors++;
			end
			if (data[213:150] !== x.total_energy) begin
				$error("total_energy exp %h got %h", x.total_energy, data[213:150]);
				errors++;
			end
			if (last !== x.last_result) begin
				$error("last_result exp %b got %b", x.last_result, last);
				errors++;
			end
			if (user !== x.overflow_flag) begin
				$error("overflow_flag exp %b got %b", x.overflow_flag, user);
				errors++;
			end
		endfunction
	endclass

	logic         clk = 0;
	logic         arst_n = 0;
	logic         cfg_we = 0;
	logic [2:0]   cfg_index = '0;
	logic [31:0]  cfg_data = '0;
	logic         s_axis_tvalid = 0;
	logic         s_axis_tready;
	logic [95:0]  s_axis_tdata = '0;
	logic         s_axis_tlast = 0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 0;
	logic [215:0] m_axis_tdata;
	logic         m_axis_tlast;
	logic         m_axis_tuser;

	morse_scoreboard sb = new();
	bit quiet = 0;
	int ready_hold = 0;
	int idle_cycles = 0;

	morse_pair_force_energy uut (.*);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	// result side: check, then pick next backpressure
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser);
		if (quiet) begin
			m_axis_tready <= 1;
		end else if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
			m_axis_tready <= 0;
		end else if ($urandom_range(4) == 0) begin
			ready_hold <= $urandom_range(0, 11);
			m_axis_tready <= 0;
		end else begin
			m_axis_tready <= 1;
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic send_atom(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit last);
		if (!quiet && $urandom_range(3) == 0) begin
			s_axis_tvalid <= 0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {z, y, x};
		s_axis_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_atom(x, y, z, last);
	endtask

	task automatic drain();
		s_axis_tvalid <= 0;
		while (sb.expected_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		sb.set_reg(idx, val);
	endtask

	// cluster: atoms a few units apart around a random base, some coincident; with noise, random atoms
	task automatic send_set(int n, bit noise);
		logic [31:0] bx, by, bz, x, y, z;
		bx = $urandom;
		by = $urandom;
		bz = $urandom;
		x = bx;
		y = by;
		z = bz;
		for (int i = 0; i < n; i++) begin
			if (noise) begin
				x = $urandom;
				y = $urandom;
				z = $urandom;
			end else if ($urandom_range(7) != 0) begin
				x = bx + $urandom_range(0, 32'h40000);
				y = by + $urandom_range(0, 32'h40000);
				z = bz + $urandom_range(0, 32'h40000);
			end
			send_atom(x, y, z, i == n - 1);
		end
	endtask

	initial begin
		logic [31:0] cfg_set[6][4];
		int items;
		int n;
		cfg_set[0] = '{32'h10000, 32'h10000, 32'h10000, 32'hA0000};
		cfg_set[1] = '{32'hFFFFFFFF, 32'h4000, 32'h20000, 32'hFFFFFFFF};
		cfg_set[2] = '{32'h0, 32'hFFFFFFFF, 32'h0, 32'h30000};
		cfg_set[3] = '{32'h20000, 32'h80000, 32'hFFFFFFFF, 32'hFFFFFFFF};
		cfg_set[4] = '{32'h18000, 32'h20000, 32'h18000, 32'h0};
		cfg_set[5] = '{32'h10000, 32'h30000, 32'h10000, 32'hA0000};
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extreme coordinates, coincident pair, lone atom, near set of three
		send_atom(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0);
		send_atom(32'h80000000, 32'h80000000, 32'h80000000, 1);
		send_atom(32'h00010000, 32'h0, 32'h0, 0);
		send_atom(32'h00010000, 32'h0, 32'h0, 1);
		send_atom(32'h0, 32'h0, 32'h0, 1);
		send_atom(32'h0, 32'h0, 32'h0, 0);
		send_atom(32'h00008000, 32'hFFFF0000, 32'h00018000, 0);
		send_atom(32'h00010000, 32'h00010000, 32'h0, 1);
		// one atom past capacity, spread out so pairs skip quickly
		for (int i = 0; i <= mpfe_pkg::MAX_ATOMS; i++)
			send_atom(32'(i * 32'h140000), 32'(-i * 32'h10000), 32'h0,
				i == mpfe_pkg::MAX_ATOMS);
		drain();
		write_reg(3'd5, 32'h12345678);

		for (int p = 0; p < 6; p++) begin
			quiet = (p == 5);
			for (int r = 0; r < 4; r++)
				write_reg(3'(r), cfg_set[p][r]);
			items = 0;
			while (items < 12) begin
				n = ($urandom_range(9) == 0) ? $urandom_range(7, 9) : $urandom_range(1, 5);
				send_set(n, $urandom_range(4) == 0);
				items += n;
			end
			drain();
		end

		repeat (50) @(posedge clk);
		if (sb.errors == 0 && sb.expected_results.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
